>>> rtl/button_debounce_long_press_core_defines.svh
// button_debounce_long_press_core_defines.svh
// Assertion macros shared by the checker files of this block.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define BDLP_ASSERT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is low.
`define BDLP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types and constants of the button debounce / long press block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEBOUNCE_TIME   = 2'd0,
        CFG_LONG_PRESS_TIME = 2'd1,
        CFG_SAMPLE_INTERVAL = 2'd2
    } cfg_index_t;

    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int NOW_BITS      = 32;

    // Lane that owns the long-press detector (select)
    localparam int SEL_IDX = 2;

    // Reset values of the configuration registers
    localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [CFG_DATA_BITS-1:0] INTERVAL_RESET   = 16'd10;

    // One input sample
    typedef struct packed {
        logic [NOW_BITS-1:0] now_ms;
        logic                up_level;
        logic                down_level;
        logic                select_level;
        logic                filament_level;
        logic                stop_level;
        logic                stop_fell;
    } in_item_t;

    // One result
    typedef struct packed {
        logic sampled;
        logic up_press;
        logic down_press;
        logic select_press;
        logic select_long;
        logic fil_runout;
        logic stop_event;
        logic filament_present;
        logic stop_active;
    } out_item_t;

    // Events reported by one button lane
    typedef struct packed {
        logic press;
        logic long_hit;
    } lane_evt_t;

    // Status reported by the filament lane
    typedef struct packed {
        logic runout;
        logic present;
    } fil_evt_t;

endpackage

>>> rtl/bdlp_button_lane.sv
// ----------------------------------------------------------------------------
// bdlp_button_lane
// Debounce and press tracking for one active-low button line.
// ----------------------------------------------------------------------------
module bdlp_button_lane
    import bdlp_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter bit HAS_LONG  = 1'b0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [TIME_BITS-1:0] now,
    input  logic                 level,
    input  logic [TIME_BITS-1:0] debounce_time,
    input  logic [TIME_BITS-1:0] long_press_time,
    output lane_evt_t            evt
);

    logic                 raw_prev_reg,   raw_prev_next;
    logic                 stable_reg,     stable_next;
    logic [TIME_BITS-1:0] edge_time_reg,  edge_time_next;
    logic [TIME_BITS-1:0] press_time_reg, press_time_next;
    logic                 held_reg,       held_next;
    logic                 long_done_reg,  long_done_next;
    logic [TIME_BITS-1:0] edge_age;
    logic [TIME_BITS-1:0] press_age;

    // Debounce and press/release tracking
    always_comb
    begin
        raw_prev_next   = level;
        edge_time_next  = (level != raw_prev_reg) ? now : edge_time_reg;
        edge_age        = now - edge_time_next;
        stable_next     = stable_reg;
        press_time_next = press_time_reg;
        held_next       = held_reg;
        long_done_next  = long_done_reg;
        evt             = '0;
        press_age       = '0;
        if (edge_age >= debounce_time)
        begin
            stable_next = level;
            // debounced press starts
            if (!level && stable_reg)
            begin
                press_time_next = now;
                held_next       = 1'b1;
                long_done_next  = 1'b0;
            end
            // debounced release; short pulse unless long press fired
            if (level && !stable_reg && held_reg)
            begin
                evt.press = !long_done_reg;
                held_next = 1'b0;
            end
            press_age = now - press_time_next;
            if (HAS_LONG && held_next && !long_done_next && press_age >= long_press_time)
            begin
                evt.long_hit   = 1'b1;
                long_done_next = 1'b1;
            end
        end
    end

    // Lane state, updated on processed samples only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_prev_reg   <= 1'b1;
            stable_reg     <= 1'b1;
            edge_time_reg  <= '0;
            press_time_reg <= '0;
            held_reg       <= 1'b0;
            long_done_reg  <= 1'b0;
        end
        else if (step)
        begin
            raw_prev_reg   <= raw_prev_next;
            stable_reg     <= stable_next;
            edge_time_reg  <= edge_time_next;
            press_time_reg <= press_time_next;
            held_reg       <= held_next;
            long_done_reg  <= long_done_next;
        end
    end

endmodule

>>> rtl/bdlp_filament_lane.sv
// ----------------------------------------------------------------------------
// bdlp_filament_lane
// Debounce of the filament sensor and runout detection.
// ----------------------------------------------------------------------------
module bdlp_filament_lane
    import bdlp_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [TIME_BITS-1:0] now,
    input  logic                 level,
    input  logic [TIME_BITS-1:0] debounce_time,
    output fil_evt_t             evt
);

    logic                 raw_prev_reg,  raw_prev_next;
    logic                 stable_reg,    stable_next;
    logic [TIME_BITS-1:0] edge_time_reg, edge_time_next;
    logic                 present;
    logic [TIME_BITS-1:0] edge_age;

    // Sensor is active low: 0 means filament present
    assign present = !level;

    // Debounce; runout on present to absent
    always_comb
    begin
        raw_prev_next  = present;
        edge_time_next = (present != raw_prev_reg) ? now : edge_time_reg;
        edge_age       = now - edge_time_next;
        stable_next    = stable_reg;
        evt.runout     = 1'b0;
        if (edge_age >= debounce_time && present != stable_reg)
        begin
            evt.runout  = stable_reg && !present;
            stable_next = present;
        end
        if (!step)
        begin
            evt.runout = 1'b0;
        end
        evt.present = step ? stable_next : stable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_prev_reg  <= 1'b1;
            stable_reg    <= 1'b1;
            edge_time_reg <= '0;
        end
        else if (step)
        begin
            raw_prev_reg  <= raw_prev_next;
            stable_reg    <= stable_next;
            edge_time_reg <= edge_time_next;
        end
    end

endmodule

>>> rtl/button_debounce_long_press_core.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_core
// Debounced buttons with select long press, filament runout and
// emergency-stop confirmation, one sample per transfer.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction | transfer when
//  --------+--------------------------------+-----------+--------------------
//  in      | in_valid, in_stall, in_data    | sink      | in_valid & !in_stall
//  out     | out_valid, out_stall, out_data | source    | out_valid & !out_stall
//  cfg     | cfg_we, cfg_addr, cfg_wdata    | sink      | cfg_we
//
//  One sample per cycle while in_stall is low; its result is registered
//  in the two-entry output buffer, which decouples the sides. All lanes
//  update their state in the cycle of the transfer; the longest path is
//  the timestamp subtract and compare in each lane. in_stall rises only
//  when both entries are full. Reset loads the default timings (50, 1000,
//  10 ms) and marks all buttons released and filament present.
// ----------------------------------------------------------------------------
module button_debounce_long_press_core
    import bdlp_pkg::*;
#(
    parameter int NUM_BUTTONS = 3,
    parameter int TIME_BITS   = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_item_t                out_data,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    localparam int NUM_PINS = 3;

    logic [CFG_DATA_BITS-1:0] debounce_reg;
    logic [CFG_DATA_BITS-1:0] long_press_reg;
    logic [CFG_DATA_BITS-1:0] interval_reg;

    logic [TIME_BITS-1:0] last_sample_reg;
    logic                 stop_pending_reg, stop_pending_next;

    logic                 push;
    logic                 pop;
    logic                 sampled;
    logic                 step;
    logic                 pend;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] since_last;
    logic [TIME_BITS-1:0] deb_t;
    logic [TIME_BITS-1:0] long_t;
    logic [NUM_PINS-1:0]  pin_level;
    logic [NUM_PINS-1:0]  btn_press;
    logic                 sel_long;
    fil_evt_t             fil_evt;
    lane_evt_t            lane_evt [NUM_BUTTONS];
    out_item_t            result;

    out_item_t main_reg,  main_next;
    logic      main_valid_reg, main_valid_next;
    out_item_t skid_reg,  skid_next;
    logic      skid_valid_reg, skid_valid_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            interval_reg   <= INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DEBOUNCE_TIME:   debounce_reg   <= cfg_wdata;
                CFG_LONG_PRESS_TIME: long_press_reg <= cfg_wdata;
                CFG_SAMPLE_INTERVAL: interval_reg   <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    // Sample gate
    assign push       = in_valid && !in_stall;
    assign now        = in_data.now_ms[TIME_BITS-1:0];
    assign since_last = now - last_sample_reg;
    assign sampled    = since_last >= TIME_BITS'(interval_reg);
    assign step       = push && sampled;
    assign deb_t      = TIME_BITS'(debounce_reg);
    assign long_t     = TIME_BITS'(long_press_reg);
    assign pin_level  = {in_data.select_level, in_data.down_level, in_data.up_level};

    // Stop edge latch; cleared when a sample is processed
    assign pend              = stop_pending_reg || in_data.stop_fell;
    assign stop_pending_next = sampled ? 1'b0 : pend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg  <= '0;
            stop_pending_reg <= 1'b0;
        end
        else if (push)
        begin
            stop_pending_reg <= stop_pending_next;
            if (sampled)
            begin
                last_sample_reg <= now;
            end
        end
    end

    // Button lanes; lanes without a pin read released
    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        logic lane_level;
        if (i < NUM_PINS)
        begin : g_pin
            assign lane_level = pin_level[i];
        end
        else
        begin : g_nopin
            assign lane_level = 1'b1;
        end
        bdlp_button_lane #(
            .TIME_BITS (TIME_BITS),
            .HAS_LONG  (i == SEL_IDX)
        ) u_lane (
            .clk             (clk),
            .rst_n           (rst_n),
            .step            (step),
            .now             (now),
            .level           (lane_level),
            .debounce_time   (deb_t),
            .long_press_time (long_t),
            .evt             (lane_evt[i])
        );
    end

    bdlp_filament_lane #(
        .TIME_BITS (TIME_BITS)
    ) u_filament (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .now           (now),
        .level         (in_data.filament_level),
        .debounce_time (deb_t),
        .evt           (fil_evt)
    );

    // Merge: map lane events onto result fields
    for (genvar p = 0; p < NUM_PINS; p++)
    begin : g_merge
        if (p < NUM_BUTTONS)
        begin : g_have
            assign btn_press[p] = lane_evt[p].press;
        end
        else
        begin : g_none
            assign btn_press[p] = 1'b0;
        end
    end

    always_comb
    begin
        sel_long = 1'b0;
        for (int k = 0; k < NUM_BUTTONS; k++)
        begin
            sel_long = sel_long | lane_evt[k].long_hit;
        end
    end

    always_comb
    begin
        result                  = '0;
        result.sampled          = sampled;
        result.up_press         = step && btn_press[0];
        result.down_press       = step && btn_press[1];
        result.select_press     = step && btn_press[SEL_IDX];
        result.select_long      = step && sel_long;
        result.fil_runout       = fil_evt.runout;
        result.stop_event       = sampled && pend && !in_data.stop_level;
        result.filament_present = fil_evt.present;
        result.stop_active      = !in_data.stop_level;
    end

    // Two-entry output buffer
    assign pop = main_valid_reg && !out_stall;

    always_comb
    begin
        main_next       = main_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg)
        begin
            main_next       = result;
            main_valid_next = push;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = result;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

>>> rtl/bdlp_checker.sv
// ----------------------------------------------------------------------------
// bdlp_checker
// Port-level checks of the button debounce / long press block.
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_core_defines.svh"

module bdlp_checker
    import bdlp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // Skipped samples carry no pulses
    `BDLP_ASSERT(a_skip_quiet, out_valid && !out_data.sampled, !(out_data.up_press || out_data.down_press || out_data.select_press || out_data.select_long || out_data.fil_runout || out_data.stop_event), "pulse on a skipped sample")

    // Long press suppresses the short select pulse
    `BDLP_ASSERT(a_sel_excl, out_valid, !(out_data.select_press && out_data.select_long), "select short and long in one result")

    // Stop event only with the line still low
    `BDLP_ASSERT(a_stop_live, out_valid && out_data.stop_event, out_data.stop_active, "stop event with stop released")

    // Runout leaves filament absent
    `BDLP_ASSERT(a_runout, out_valid && out_data.fil_runout, !out_data.filament_present, "runout while filament present")

    // A stalled result holds
    `BDLP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind button_debounce_long_press_core bdlp_checker u_bdlp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> sim/tb_button_debounce_long_press_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_debounce_long_press_core
// Self-checking bench for the button debounce / long press core. A short
// table of hand-built pin samples covers button presses, the select long
// press, filament runout, stop confirmation and timestamp wrap. Random
// pin activity follows under several timing settings and handshake gap
// patterns. A behavioral debouncer model predicts each result but those
// of the typed first rows; every output transfer is checked field by field.
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press_core;
    import bdlp_pkg::*;

    localparam int LANES     = 3;
    localparam int DIR_ROWS  = 26;
    localparam int DIR_TYPED = 4;
    localparam int PHASES    = 8;
    localparam int BURST     = 100;

    // Index past the end of the register map; writes to it are dropped
    localparam logic [CFG_ADDR_BITS-1:0] CFG_UNMAPPED = 2'd3;

    typedef enum int {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    in_item_t                 in_data   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    out_item_t                out_data;
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    // Handshake gap rates in percent
    int idle_pct  = 0;
    int stall_pct = 0;
    bit mismatch_seen = 1'b0;

    // Results still owed by the core, oldest first
    out_item_t pulse_q [$];

    // Debouncer model: timing settings
    logic [CFG_DATA_BITS-1:0] db_ms = DEBOUNCE_RESET;
    logic [CFG_DATA_BITS-1:0] lp_ms = LONG_PRESS_RESET;
    logic [CFG_DATA_BITS-1:0] iv_ms = INTERVAL_RESET;

    // Debouncer model: state
    logic [31:0]      t_last       = '0;
    logic             stop_latched = 1'b0;
    logic [LANES-1:0] key_raw      = '1;
    logic [LANES-1:0] key_stable   = '1;
    logic [31:0]      key_edge_t [LANES] = '{default: '0};
    logic [31:0]      key_down_t [LANES] = '{default: '0};
    logic [LANES-1:0] key_held      = '0;
    logic [LANES-1:0] key_long_done = '0;
    logic             fil_raw      = 1'b1;
    logic             fil_stable   = 1'b1;
    logic [31:0]      fil_edge_t   = '0;

    // Random pin state: [0] up, [1] down, [2] select, [3] filament, [4] stop
    logic [4:0]  pins     = 5'b10111;
    logic [31:0] clock_ms = '0;

    // Timing settings and gap pattern of each random phase
    int        ph_db  [PHASES] = '{50, 0, 65535, 5, 20, 0, 65535, 100};
    int        ph_lp  [PHASES] = '{1000, 0, 65535, 40, 200, 65535, 0, 500};
    int        ph_iv  [PHASES] = '{10, 0, 65535, 1, 0, 3, 0, 25};
    gap_mode_t ph_gap [PHASES] = '{GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH,
                                   GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH};

    in_item_t  dir_in   [DIR_ROWS];
    out_item_t dir_want [DIR_TYPED];

    button_debounce_long_press_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Advance the debouncer model by one pin sample and return its result
    function automatic out_item_t debounce_sample(input in_item_t s);
        out_item_t        r;
        logic [LANES-1:0] lvl;
        logic [LANES-1:0] press;
        logic [31:0]      now;
        logic             prev;
        logic             present;
        r     = '0;
        press = '0;
        now   = s.now_ms;
        lvl   = {s.select_level, s.down_level, s.up_level};
        r.stop_active = !s.stop_level;
        if (s.stop_fell)
            stop_latched = 1'b1;
        if (now - t_last >= iv_ms)
        begin
            r.sampled = 1'b1;
            t_last = now;
            if (stop_latched)
            begin
                stop_latched = 1'b0;
                r.stop_event = !s.stop_level;
            end
            // button lanes
            for (int i = 0; i < LANES; i++)
            begin
                if (lvl[i] != key_raw[i])
                    key_edge_t[i] = now;
                key_raw[i] = lvl[i];
                if (now - key_edge_t[i] < db_ms)
                    continue;
                prev = key_stable[i];
                key_stable[i] = lvl[i];
                if (!lvl[i] && prev)
                begin
                    key_down_t[i]    = now;
                    key_held[i]      = 1'b1;
                    key_long_done[i] = 1'b0;
                end
                if (lvl[i] && !prev && key_held[i])
                begin
                    if (!key_long_done[i])
                        press[i] = 1'b1;
                    key_held[i] = 1'b0;
                end
                if (i == SEL_IDX && key_held[i] && !key_long_done[i] &&
                    now - key_down_t[i] >= lp_ms)
                begin
                    r.select_long    = 1'b1;
                    key_long_done[i] = 1'b1;
                end
            end
            // filament lane, active-low sensor
            present = !s.filament_level;
            if (present != fil_raw)
                fil_edge_t = now;
            fil_raw = present;
            if (now - fil_edge_t >= db_ms && present != fil_stable)
            begin
                if (fil_stable && !present)
                    r.fil_runout = 1'b1;
                fil_stable = present;
            end
        end
        r.up_press         = press[0];
        r.down_press       = press[1];
        r.select_press     = press[2];
        r.filament_present = fil_stable;
        return r;
    endfunction

    function automatic in_item_t pin_read(input logic [31:0] now, input logic up,
                                          input logic dn, input logic sel,
                                          input logic fil, input logic stp,
                                          input logic fell);
        in_item_t s;
        s.now_ms         = now;
        s.up_level       = up;
        s.down_level     = dn;
        s.select_level   = sel;
        s.filament_level = fil;
        s.stop_level     = stp;
        s.stop_fell      = fell;
        return s;
    endfunction

    // Queue the expected result, then hold the sample until it transfers
    task automatic send_sample(input in_item_t s, input bit typed, input out_item_t want);
        out_item_t predicted;
        predicted = debounce_sample(s);
        pulse_q.push_back(typed ? want : predicted);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        case (addr)
            CFG_DEBOUNCE_TIME:   db_ms = val;
            CFG_LONG_PRESS_TIME: lp_ms = val;
            CFG_SAMPLE_INTERVAL: iv_ms = val;
            default: ;
        endcase
    endtask

    // Stop sending and wait until every owed result has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pulse_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random pin activity; timestamps step on the scale of the settings
    task automatic random_burst(input int count);
        in_item_t s;
        int       span;
        int       pick;
        int       rate [5];
        logic     stop_prev;
        logic     fell;
        rate = '{6, 6, 10, 6, 8};
        for (int k = 0; k < count; k++)
        begin
            span = (int'(db_ms) + int'(lp_ms) / 8) / 2 + 4;
            pick = $urandom_range(99);
            if (pick < 3)
                clock_ms = $urandom();
            else if (pick < 12)
                clock_ms = clock_ms + $urandom_range(0, int'(iv_ms));
            else
                clock_ms = clock_ms + $urandom_range(int'(iv_ms), int'(iv_ms) + span);
            stop_prev = pins[4];
            for (int j = 0; j < 5; j++)
                if ($urandom_range(rate[j] - 1) == 0)
                    pins[j] = ~pins[j];
            fell = (stop_prev && !pins[4]) || ($urandom_range(9) == 0);
            s = pin_read(clock_ms, pins[0], pins[1], pins[2], pins[3], pins[4], fell);
            send_sample(s, 1'b0, '0);
        end
    endtask

    task automatic check_field(input string name, input logic got, input logic want);
        if (got !== want)
        begin
            mismatch_seen = 1'b1;
            $display("%0t ns: %s expected %0b actual %0b", $time, name, want, got);
        end
    endtask

    // Output side: random stall and comparison of every transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pulse_q.size() == 0)
                begin
                    mismatch_seen = 1'b1;
                    $display("%0t ns: unexpected result, expected none, actual %b",
                             $time, out_data);
                end
                else
                begin
                    out_item_t want;
                    want = pulse_q.pop_front();
                    check_field("sampled",          out_data.sampled,          want.sampled);
                    check_field("up_press",         out_data.up_press,         want.up_press);
                    check_field("down_press",       out_data.down_press,       want.down_press);
                    check_field("select_press",     out_data.select_press,     want.select_press);
                    check_field("select_long",      out_data.select_long,      want.select_long);
                    check_field("fil_runout",       out_data.fil_runout,       want.fil_runout);
                    check_field("stop_event",       out_data.stop_event,       want.stop_event);
                    check_field("filament_present", out_data.filament_present, want.filament_present);
                    check_field("stop_active",      out_data.stop_active,      want.stop_active);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Stimulus
    initial
    begin
        // now, up, down, select, filament, stop, stop_fell
        dir_in = '{
            pin_read(32'd0,    1, 1, 1, 0, 1, 0),  // reset state, interval not yet met
            pin_read(32'd5,    1, 1, 1, 0, 0, 1),  // stop edge latched while skipped
            pin_read(32'd10,   1, 1, 1, 0, 0, 0),  // latched edge confirmed
            pin_read(32'd20,   0, 1, 1, 0, 1, 1),  // edge seen but line back high
            pin_read(32'd80,   0, 1, 1, 0, 1, 0),  // up debounced pressed
            pin_read(32'd90,   1, 1, 1, 0, 1, 0),
            pin_read(32'd145,  1, 1, 1, 0, 1, 0),  // up press completes
            pin_read(32'd200,  1, 0, 0, 0, 1, 0),
            pin_read(32'd260,  1, 0, 0, 0, 1, 0),
            pin_read(32'd300,  1, 1, 1, 0, 1, 0),
            pin_read(32'd355,  1, 1, 1, 0, 1, 0),  // down and short select together
            pin_read(32'd400,  1, 1, 0, 0, 1, 0),
            pin_read(32'd455,  1, 1, 0, 0, 1, 0),
            pin_read(32'd1460, 1, 1, 0, 0, 1, 0),  // long press fires
            pin_read(32'd1470, 1, 1, 0, 0, 1, 0),  // and only once
            pin_read(32'd1500, 1, 1, 1, 0, 1, 0),
            pin_read(32'd1560, 1, 1, 1, 0, 1, 0),  // release after long: no short pulse
            pin_read(32'd1600, 1, 1, 1, 1, 1, 0),
            pin_read(32'd1660, 1, 1, 1, 1, 1, 0),  // runout
            pin_read(32'd1670, 1, 1, 1, 0, 1, 0),
            pin_read(32'd1730, 1, 1, 1, 0, 1, 0),  // filament back
            pin_read(32'd1740, 0, 1, 1, 0, 1, 0),
            pin_read(32'd1750, 1, 1, 1, 0, 1, 0),  // bounce shorter than debounce
            pin_read(32'd1755, 0, 1, 1, 0, 1, 0),  // inside the interval, skipped
            pin_read(32'hFFFF_FFFF, 1, 1, 1, 0, 1, 0),
            pin_read(32'd9,    1, 1, 1, 0, 0, 1)   // timestamp wrap, stop confirmed
        };
        // sampled, up, down, select, long, runout, stop_event, present, active
        dir_want = '{
            out_item_t'(9'b0_0000_00_1_0),
            out_item_t'(9'b0_0000_00_1_1),
            out_item_t'(9'b1_0000_01_1_1),
            out_item_t'(9'b1_0000_00_1_0)
        };
        clock_ms = 32'd9;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset timings
        for (int n = 0; n < DIR_ROWS; n++)
            send_sample(dir_in[n], n < DIR_TYPED, dir_want[n < DIR_TYPED ? n : 0]);
        settle();

        // random phases, each under new timings and a gap pattern
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(CFG_DEBOUNCE_TIME, CFG_DATA_BITS'(ph_db[p]));
            write_reg(CFG_LONG_PRESS_TIME, CFG_DATA_BITS'(ph_lp[p]));
            write_reg(CFG_UNMAPPED, CFG_DATA_BITS'($urandom()));
            write_reg(CFG_SAMPLE_INTERVAL, CFG_DATA_BITS'(ph_iv[p]));
            cfg_we <= 1'b0;
            case (ph_gap[p])
                GAP_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
                GAP_SENDER:   begin idle_pct = 85; stall_pct = 0;  end
                GAP_RECEIVER: begin idle_pct = 0;  stall_pct = 85; end
                default:      begin idle_pct = 35; stall_pct = 35; end
            endcase
            random_burst(BURST);
            settle();
        end

        repeat (8) @(posedge clk);
        if (!mismatch_seen && pulse_q.size() == 0)
            $display("[button_debounce_long_press_core] OK");
        else
            $display("[button_debounce_long_press_core] ERROR");
        $finish;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("[button_debounce_long_press_core] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bdlp_pkg.sv
rtl/bdlp_button_lane.sv
rtl/bdlp_filament_lane.sv
rtl/button_debounce_long_press_core.sv
rtl/bdlp_checker.sv
sim/tb_button_debounce_long_press_core.sv
